### sv/deqb_pkg.sv
// ----------------------------------------------------------------------------
// deqb_pkg
// shared types, constants and codes for the double-ended queue buffer
// ----------------------------------------------------------------------------
package deqb_pkg;

	// capacity of the deque in words
	localparam int DEPTH = 16;

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = IDX_W + 1;
	localparam int WORD_W = 32;
	localparam int OCC_W  = 5;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;

	// stream payload widths
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 40;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_BACK  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_BACK   = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_LOAD = 2'd2
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic latch_in;
		logic exec;
		logic load_out;
	} ctl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

### sv/deqb_ctrl.sv
// ----------------------------------------------------------------------------
// deqb_ctrl
// sequencer: take a transaction, run the operation, hand result to output reg
// ----------------------------------------------------------------------------
module deqb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  deqb_pkg::dp_stat_t  stat,
	output deqb_pkg::ctl_cmd_t  cmd
);

	deqb_pkg::state_t state_q;
	deqb_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deqb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx     = state_q;
		in_ready     = 1'b0;
		cmd.latch_in = 1'b0;
		cmd.exec     = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			deqb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_nx     = deqb_pkg::ST_EXEC;
				end
			end
			deqb_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_nx = deqb_pkg::ST_LOAD;
			end
			deqb_pkg::ST_LOAD: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = deqb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = deqb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### sv/deqb_dpath.sv
// ----------------------------------------------------------------------------
// deqb_dpath
// circular buffer store, head pointer, fill counter and output register
// ----------------------------------------------------------------------------
module deqb_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  deqb_pkg::ctl_cmd_t                cmd,
	output deqb_pkg::dp_stat_t                stat,
	input  logic [deqb_pkg::CMD_W-1:0]        in_cmd,
	input  logic signed [deqb_pkg::WORD_W-1:0] in_word,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [deqb_pkg::WORD_W-1:0] out_value,
	output logic [deqb_pkg::STAT_W-1:0]       out_status,
	output logic [deqb_pkg::OCC_W-1:0]        out_occ
);

	localparam int IDX_W  = deqb_pkg::IDX_W;
	localparam int CNT_W  = deqb_pkg::CNT_W;
	localparam int SUM_W  = deqb_pkg::SUM_W;
	localparam int WORD_W = deqb_pkg::WORD_W;
	localparam int DEPTH  = deqb_pkg::DEPTH;

	logic [WORD_W-1:0] mem [DEPTH];

	deqb_pkg::cmd_t          cmd_q;
	logic [WORD_W-1:0]       word_q;
	logic [IDX_W-1:0]        head_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [WORD_W-1:0]       rd_data_q;
	deqb_pkg::status_t       stat_q;
	logic                    pop_ok_q;

	logic                    out_valid_q;
	logic [WORD_W-1:0]       out_value_q;
	deqb_pkg::status_t       out_status_q;
	logic [deqb_pkg::OCC_W-1:0] out_occ_q;

	logic                    full;
	logic                    empty;
	logic                    is_pop;
	logic [IDX_W-1:0]        head_dec;
	logic [IDX_W-1:0]        head_inc;
	logic [CNT_W-1:0]        back_off;
	logic [SUM_W-1:0]        back_sum;
	logic [IDX_W-1:0]        back_slot;

	logic [IDX_W-1:0]        slot;
	logic                    mem_we;
	logic                    pop_ok;
	deqb_pkg::status_t       exec_stat;
	logic [IDX_W-1:0]        head_nx;
	logic [CNT_W-1:0]        cnt_nx;

	// input latch
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			cmd_q  <= deqb_pkg::cmd_t'(in_cmd);
			word_q <= in_word;
		end
	end

	assign full   = (cnt_q == CNT_W'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign is_pop = (cmd_q == deqb_pkg::CMD_POP_FRONT) || (cmd_q == deqb_pkg::CMD_POP_BACK);

	// pointer arithmetic, wraps at DEPTH
	assign head_dec = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - 1'b1;
	assign head_inc = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign back_off = is_pop ? cnt_q - 1'b1 : cnt_q;
	assign back_sum = SUM_W'(head_q) + SUM_W'(back_off);
	assign back_slot = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
	                                              : IDX_W'(back_sum);

	always_comb begin
		slot      = head_q;
		mem_we    = 1'b0;
		pop_ok    = 1'b0;
		exec_stat = deqb_pkg::STAT_OK;
		head_nx   = head_q;
		cnt_nx    = cnt_q;
		case (cmd_q)
			deqb_pkg::CMD_PUSH_FRONT: begin
				if (full) begin
					exec_stat = deqb_pkg::STAT_FULL;
				end else begin
					slot    = head_dec;
					mem_we  = 1'b1;
					head_nx = head_dec;
					cnt_nx  = cnt_q + 1'b1;
				end
			end
			deqb_pkg::CMD_PUSH_BACK: begin
				if (full) begin
					exec_stat = deqb_pkg::STAT_FULL;
				end else begin
					slot   = back_slot;
					mem_we = 1'b1;
					cnt_nx = cnt_q + 1'b1;
				end
			end
			deqb_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					exec_stat = deqb_pkg::STAT_EMPTY;
				end else begin
					slot    = head_q;
					pop_ok  = 1'b1;
					head_nx = head_inc;
					cnt_nx  = cnt_q - 1'b1;
				end
			end
			deqb_pkg::CMD_POP_BACK: begin
				if (empty) begin
					exec_stat = deqb_pkg::STAT_EMPTY;
				end else begin
					slot   = back_slot;
					pop_ok = 1'b1;
					cnt_nx = cnt_q - 1'b1;
				end
			end
			default: begin
				exec_stat = deqb_pkg::STAT_OK;
			end
		endcase
	end

	// single-port store, registered read
	always_ff @(posedge clk) begin
		if (cmd.exec && mem_we) begin
			mem[slot] <= word_q;
		end
		if (cmd.exec) begin
			rd_data_q <= mem[slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.exec) begin
			head_q <= head_nx;
			cnt_q  <= cnt_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			stat_q   <= exec_stat;
			pop_ok_q <= pop_ok;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_value_q  <= pop_ok_q ? rd_data_q : '0;
			out_status_q <= stat_q;
			out_occ_q    <= deqb_pkg::OCC_W'(cnt_q);
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_value     = out_value_q;
	assign out_status    = out_status_q;
	assign out_occ       = out_occ_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("fill count above capacity");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= IDX_W'(DEPTH - 1))
		else $error("head pointer out of range");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && mem_we |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("push did not grow fill count");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && pop_ok |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("pop did not shrink fill count");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output register overwritten before taken");

endmodule

### sv/double_ended_queue_buffer_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_buffer_top
// fixed-capacity deque of signed 32-bit words with push/pop at both ends
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser = cmd, tdata = push_value
// m_axis    out  m_axis_tvalid/m_axis_tready  tuser = status,
//                                             tdata = pop_value, occupancy
//
// each transaction passes in turn through latch, execute (one store access) and load of
// the output register; the single store port and the sequencer set the pace
// the input is taken again as soon as the result sits in the output register,
// so a stalled output holds back at most one further transaction
// reset clears head pointer, fill count, sequencer and output valid; the store
// itself holds no reset and needs no clearing pass
// ----------------------------------------------------------------------------
module double_ended_queue_buffer_top (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [31:0] push_value
	input  logic [deqb_pkg::S_DATA_W-1:0]     s_axis_tdata,
	// [1:0] cmd
	input  logic [deqb_pkg::CMD_W-1:0]        s_axis_tuser,

	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [31:0] pop_value, [36:32] occupancy, [39:37] zero
	output logic [deqb_pkg::M_DATA_W-1:0]     m_axis_tdata,
	// [1:0] status
	output logic [deqb_pkg::STAT_W-1:0]       m_axis_tuser
);

	localparam int PAD_W = deqb_pkg::M_DATA_W - deqb_pkg::WORD_W - deqb_pkg::OCC_W;

	// controller <-> datapath
	deqb_pkg::ctl_cmd_t cmd;
	deqb_pkg::dp_stat_t stat;

	// result fields from the output register
	logic signed [deqb_pkg::WORD_W-1:0] pop_value;
	logic [deqb_pkg::STAT_W-1:0]        status;
	logic [deqb_pkg::OCC_W-1:0]         occupancy;

	// sequencer: idle -> exec -> load, input ready only while idle
	deqb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// store, pointers and output register
	deqb_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_cmd     (s_axis_tuser),
		.in_word    (s_axis_tdata[deqb_pkg::WORD_W-1:0]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_value  (pop_value),
		.out_status (status),
		.out_occ    (occupancy)
	);

	// pack result, pop_value lowest, zero fill to whole bytes
	assign m_axis_tdata = {{PAD_W{1'b0}}, occupancy, pop_value};
	assign m_axis_tuser = status;

endmodule

### dv/deqb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deqb_checker
// watches both stream channels of the deque, keeps its own copy of the
// deque contents and compares every outgoing transaction with the answer
// that the matching command should give
// ----------------------------------------------------------------------------
module deqb_checker
	import deqb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [S_DATA_W-1:0]   s_axis_tdata,
	input  logic [CMD_W-1:0]      s_axis_tuser,

	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [M_DATA_W-1:0]   m_axis_tdata,
	input  logic [STAT_W-1:0]     m_axis_tuser,

	output int                    mismatch_count,
	output int                    answers_pending
);

	typedef struct packed {
		logic [WORD_W-1:0] pop_value;
		logic [STAT_W-1:0] status;
		logic [OCC_W-1:0]  occupancy;
	} deque_answer_t;

	// shadow deque, same circular layout as the block
	logic [WORD_W-1:0] slot_word [DEPTH];
	int                front_slot;
	int                words_held;

	deque_answer_t     deque_answers [$];
	deque_answer_t     want;
	int                fails;

	function automatic deque_answer_t apply_deque_op(cmd_t op, logic [WORD_W-1:0] word);
		deque_answer_t ans;
		ans.pop_value = '0;
		ans.status    = STAT_OK;
		if (op == CMD_PUSH_FRONT || op == CMD_PUSH_BACK) begin
			if (words_held >= DEPTH) begin
				ans.status = STAT_FULL;
			end else if (op == CMD_PUSH_FRONT) begin
				front_slot = (front_slot + DEPTH - 1) % DEPTH;
				slot_word[front_slot] = word;
				words_held++;
			end else begin
				slot_word[(front_slot + words_held) % DEPTH] = word;
				words_held++;
			end
		end else begin
			if (words_held == 0) begin
				ans.status = STAT_EMPTY;
			end else if (op == CMD_POP_FRONT) begin
				ans.pop_value = slot_word[front_slot];
				front_slot = (front_slot + 1) % DEPTH;
				words_held--;
			end else begin
				ans.pop_value = slot_word[(front_slot + words_held - 1) % DEPTH];
				words_held--;
			end
		end
		ans.occupancy = OCC_W'(words_held);
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_slot = 0;
			words_held = 0;
			fails      = 0;
			deque_answers.delete();
			mismatch_count  <= 0;
			answers_pending <= 0;
		end else begin
			// results first: a command accepted on this edge cannot answer on it
			if (m_axis_tvalid && m_axis_tready) begin
				if (deque_answers.size() == 0) begin
					$error("result transaction with no command outstanding: tdata %h tuser %h",
						m_axis_tdata, m_axis_tuser);
					fails++;
				end else begin
					want = deque_answers.pop_front();
					if (m_axis_tdata[31:0] !== want.pop_value) begin
						$error("pop_value: expected %0d, got %0d",
							$signed(want.pop_value), $signed(m_axis_tdata[31:0]));
						fails++;
					end
					if (m_axis_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
						fails++;
					end
					if (m_axis_tdata[36:32] !== want.occupancy) begin
						$error("occupancy: expected %0d, got %0d",
							want.occupancy, m_axis_tdata[36:32]);
						fails++;
					end
					if (m_axis_tdata[39:37] !== 3'b000) begin
						$error("tdata pad: expected 0, got %0d", m_axis_tdata[39:37]);
						fails++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				deque_answers.push_back(apply_deque_op(cmd_t'(s_axis_tuser), s_axis_tdata));
			end
			answers_pending <= deque_answers.size();
			mismatch_count  <= fails;
		end
	end

endmodule

### dv/tb_double_ended_queue_buffer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_buffer_top
// drives push and pop commands into the deque under several idle and stall
// mixes; a checker beside the block predicts and compares every answer
// ----------------------------------------------------------------------------
module tb_double_ended_queue_buffer_top;
	import deqb_pkg::*;

	// cycles with no transaction on either channel before the run is abandoned
	localparam int WATCHDOG_LIMIT = 5000;
	// quiet cycles after the last answer
	localparam int TAIL_CYCLES    = 12;
	localparam int RANDOM_PER_PHASE = 270;

	logic                  clk = 1'b0;
	logic                  arst_n;

	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_DATA_W-1:0]   s_axis_tdata;
	logic [CMD_W-1:0]      s_axis_tuser;

	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_axis_tdata;
	logic [STAT_W-1:0]     m_axis_tuser;

	int                    mismatch_count;
	int                    answers_pending;

	// percent of cycles the command side holds back / the result side stalls
	int                    sender_idle_pct = 0;
	int                    receiver_stall_pct = 0;
	int                    quiet_cycles = 0;

	always #5 clk = ~clk;

	double_ended_queue_buffer_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	deqb_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.mismatch_count  (mismatch_count),
		.answers_pending (answers_pending)
	);

	// result side back-pressure, redrawn every cycle
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// watchdog: counts cycles in which no transaction moves on either channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// word mix weighted toward the sign and zero corners
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// one command transaction; entered and left just after a rising edge,
	// so tvalid gets a single nonblocking update per step
	task automatic send_cmd(input cmd_t op, input logic [WORD_W-1:0] word);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= word;
		// the handshake is sampled with the values present at the edge
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// hold the command side until every answer is back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (answers_pending != 0);
	endtask

	// runs of push-heavy, pop-heavy and balanced traffic so the deque keeps
	// crossing between empty and full
	task automatic send_random(input int count);
		int                left;
		int                run_len;
		int                push_pct;
		cmd_t              op;
		logic [WORD_W-1:0] word;
		left = count;
		while (left > 0) begin
			run_len = $urandom_range(8, 40);
			case ($urandom_range(0, 2))
				0: push_pct = 85;
				1: push_pct = 15;
				default: push_pct = 50;
			endcase
			while (run_len > 0 && left > 0) begin
				if ($urandom_range(0, 99) < push_pct) begin
					op = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
				end else begin
					op = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
				end
				if ($urandom_range(0, 3) == 0) begin
					// weighted corners on pushes, ignored on pops
					word = pick_word();
				end else begin
					word = $urandom;
				end
				send_cmd(op, word);
				run_len--;
				left--;
			end
		end
	endtask

	initial begin
		int i;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_PUSH_FRONT;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme words at both ends, pops from both ends, pops on
		// an empty deque, then fill to capacity and push into the full deque
		send_cmd(CMD_PUSH_FRONT, 32'h8000_0000);
		send_cmd(CMD_PUSH_BACK,  32'h7fff_ffff);
		send_cmd(CMD_POP_BACK,   $urandom);
		send_cmd(CMD_POP_FRONT,  $urandom);
		send_cmd(CMD_POP_FRONT,  $urandom);
		send_cmd(CMD_POP_BACK,   $urandom);
		for (i = 0; i < DEPTH; i++) begin
			if (i == 0) begin
				send_cmd(CMD_PUSH_FRONT, 32'h0000_0000);
			end else if (i == 1) begin
				send_cmd(CMD_PUSH_BACK, 32'hffff_ffff);
			end else begin
				send_cmd(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_word());
			end
		end
		send_cmd(CMD_PUSH_FRONT, pick_word());
		send_cmd(CMD_PUSH_BACK,  pick_word());

		// random traffic, one phase per idle/stall mix, drained between phases
		for (i = 0; i < 4; i++) begin
			case (i)
				0: begin
					sender_idle_pct    <= 0;
					receiver_stall_pct <= 0;
				end
				1: begin
					sender_idle_pct    <= 59;
					receiver_stall_pct <= 0;
				end
				2: begin
					sender_idle_pct    <= 0;
					receiver_stall_pct <= 59;
				end
				default: begin
					sender_idle_pct    <= 25;
					receiver_stall_pct <= 25;
				end
			endcase
			wait_drained();
			send_random(RANDOM_PER_PHASE);
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
